[sv/vcsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vending controller package
// Widths, command and status codes, reset values and beat layouts shared by
// the vending controller core and its checker.
// ----------------------------------------------------------------------------
package vcsc_pkg;

    localparam int NUM_PRODUCTS = 6;
    localparam int NUM_PRICED   = 6;
    localparam int NUM_ACTIVE   = (NUM_PRODUCTS < NUM_PRICED) ? NUM_PRODUCTS : NUM_PRICED;
    localparam int MASK_W       = 6;

    localparam int FUNC_W    = 3;
    localparam int KIND_W    = 2;
    localparam int PROD_W    = 3;
    localparam int STATUS_W  = 3;
    localparam int AMOUNT_W  = 32;
    localparam int CREDIT_W  = 16;
    localparam int STOCK_W   = 8;
    localparam int PRICE_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 64;

    // Command codes
    localparam logic [FUNC_W-1:0] FUNC_INSERT  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SELECT  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_RETURN  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_REPORT  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_RESTOCK = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_COIN_TAKEN  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_VENDED      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SOLD_OUT    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SHORT_FUNDS = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RETURNED    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_SALES       = 3'd5;
    localparam logic [STATUS_W-1:0] ST_RESTOCKED   = 3'd6;

    // Coin kinds
    localparam logic [KIND_W-1:0] COIN_100  = 2'd0;
    localparam logic [KIND_W-1:0] COIN_500  = 2'd1;
    localparam logic [KIND_W-1:0] COIN_1000 = 2'd2;

    // Configuration register indexes; prices occupy 0 to NUM_PRICED-1
    localparam logic [CFG_IDX_W-1:0] CFG_RESTOCK_LEVEL = 3'd6;

    localparam logic [STOCK_W-1:0] RESTOCK_RESET = 8'd10;

    typedef logic [PRICE_W-1:0] price_t;
    typedef logic [STOCK_W-1:0] stock_t;

    typedef struct packed {
        logic [PROD_W-1:0] product;
        logic [KIND_W-1:0] coin_kind;
        logic [FUNC_W-1:0] func;
    } cmd_t;

    typedef struct packed {
        logic [PROD_W-1:0]   vended_product;
        logic [MASK_W-1:0]   sold_out_mask;
        logic [CREDIT_W-1:0] credit_now;
        logic [AMOUNT_W-1:0] amount;
        logic [STATUS_W-1:0] status;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    function automatic logic [CREDIT_W:0] coin_value(input logic [KIND_W-1:0] kind);
        logic [CREDIT_W:0] v;
        case (kind)
            COIN_100:  v = 17'd100;
            COIN_500:  v = 17'd500;
            COIN_1000: v = 17'd1000;
            default:   v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic price_t price_reset(input int idx);
        price_t v;
        case (idx)
            2:       v = 16'd500;
            4:       v = 16'd500;
            5:       v = 16'd300;
            default: v = 16'd700;
        endcase
        return v;
    endfunction

endpackage

[sv/vending_credit_stock_controller_core.sv]
`timescale 1ns / 1ps
// A command accepted at one edge shows its result beat on m_tvalid right
// after that edge if the output register is free, else via the skid register.
// Throughput: one command per cycle while the skid register is empty; state is
// read and updated in the cycle of acceptance, and s_tready is registered.
// Reset: synchronous, active low; credit and sales clear, every stock loads
// ten, prices and the restock level return to their defaults.
// ----------------------------------------------------------------------------
// Vending controller core
// Six-product credit and stock keeper: coin insertion, selection with stock
// and price checks, credit return, sales report and restock.
// ----------------------------------------------------------------------------
module vending_credit_stock_controller_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: func[2:0], coin_kind[4:3], product[7:5]
    input  logic [vcsc_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: status[2:0], amount[34:3], credit_now[50:35],
    // sold_out_mask[56:51], vended_product[59:57], zero [63:60]
    output logic [vcsc_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            cfg_we,
    input  logic [vcsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vcsc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import vcsc_pkg::*;

    price_t               price_reg [NUM_PRICED];
    stock_t               restock_level_reg;
    logic [CREDIT_W-1:0]  credit_reg, credit_next;
    logic [AMOUNT_W-1:0]  sales_reg, sales_next;
    stock_t               stock_reg [NUM_ACTIVE];
    stock_t               stock_next [NUM_ACTIVE];

    logic                 out_valid_reg, skid_valid_reg;
    result_t              out_data_reg, skid_data_reg;

    cmd_t                 cmd;
    result_t              res;
    logic                 res_valid;
    logic                 accept, pop;
    logic                 prod_ok;
    stock_t               stock_sel;
    price_t               price_sel;
    logic [CREDIT_W:0]    credit_sum;
    logic [AMOUNT_W:0]    sales_sum;

    assign cmd      = cmd_t'(s_tdata);
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign pop      = out_valid_reg && m_tready;
    assign m_tdata  = {(M_TDATA_W - RESULT_W)'(0), out_data_reg};

    always_comb begin
        stock_sel = '0;
        price_sel = '0;
        for (int p = 0; p < NUM_ACTIVE; p++) begin
            if (cmd.product == PROD_W'(p)) begin
                stock_sel = stock_reg[p];
                price_sel = price_reg[p];
            end
        end
        prod_ok    = (32'(cmd.product) < NUM_ACTIVE);
        credit_sum = {1'b0, credit_reg} + coin_value(cmd.coin_kind);
        sales_sum  = {1'b0, sales_reg} + (AMOUNT_W + 1)'(price_sel);

        credit_next = credit_reg;
        sales_next  = sales_reg;
        for (int p = 0; p < NUM_ACTIVE; p++) begin
            stock_next[p] = stock_reg[p];
        end
        res           = '0;
        res_valid     = 1'b1;

        unique case (cmd.func)
            FUNC_INSERT: begin
                credit_next = credit_sum[CREDIT_W] ? '1 : credit_sum[CREDIT_W-1:0];
                res.status  = ST_COIN_TAKEN;
            end
            FUNC_SELECT: begin
                if (!prod_ok || stock_sel == '0) begin
                    res.status = ST_SOLD_OUT;
                end else if (credit_reg < price_sel) begin
                    res.status = ST_SHORT_FUNDS;
                end else begin
                    credit_next = credit_reg - price_sel;
                    sales_next  = sales_sum[AMOUNT_W] ? '1 : sales_sum[AMOUNT_W-1:0];
                    for (int p = 0; p < NUM_ACTIVE; p++) begin
                        if (cmd.product == PROD_W'(p)) begin
                            stock_next[p] = stock_reg[p] - 1'b1;
                        end
                    end
                    res.status         = ST_VENDED;
                    res.vended_product = cmd.product;
                end
            end
            FUNC_RETURN: begin
                res.amount  = AMOUNT_W'(credit_reg);
                credit_next = '0;
                res.status  = ST_RETURNED;
            end
            FUNC_REPORT: begin
                res.amount = sales_reg;
                res.status = ST_SALES;
            end
            FUNC_RESTOCK: begin
                for (int p = 0; p < NUM_ACTIVE; p++) begin
                    stock_next[p] = restock_level_reg;
                end
                sales_next  = '0;
                credit_next = '0;
                res.status  = ST_RESTOCKED;
            end
            default: begin
                // Unknown commands are consumed silently.
                res_valid = 1'b0;
            end
        endcase

        res.credit_now = credit_next;
        for (int p = 0; p < NUM_ACTIVE; p++) begin
            if (p < MASK_W) begin
                res.sold_out_mask[p] = (stock_next[p] == '0);
            end
        end
    end

    // Command state and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PRICED; i++) begin
                price_reg[i] <= price_reset(i);
            end
            restock_level_reg <= RESTOCK_RESET;
            credit_reg        <= '0;
            sales_reg         <= '0;
            for (int p = 0; p < NUM_ACTIVE; p++) begin
                stock_reg[p] <= RESTOCK_RESET;
            end
        end else begin
            if (cfg_we) begin
                for (int i = 0; i < NUM_PRICED; i++) begin
                    if (cfg_index == CFG_IDX_W'(i)) begin
                        price_reg[i] <= cfg_wdata;
                    end
                end
                if (cfg_index == CFG_RESTOCK_LEVEL) begin
                    restock_level_reg <= cfg_wdata[STOCK_W-1:0];
                end
            end
            if (accept) begin
                credit_reg <= credit_next;
                sales_reg  <= sales_next;
                for (int p = 0; p < NUM_ACTIVE; p++) begin
                    stock_reg[p] <= stock_next[p];
                end
            end
        end
    end

    // Output register with a skid stage behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (accept && res_valid) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (accept && res_valid) begin
            if (!out_valid_reg || pop) begin
                out_data_reg <= res;
            end else begin
                skid_data_reg <= res;
            end
        end
    end

endmodule

[sv/vcsc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vending controller port checker
// Watches the core's stream ports for stalled beats, status coding and the
// field values that each status implies.
// ----------------------------------------------------------------------------
module vcsc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [vcsc_pkg::M_TDATA_W-1:0] m_tdata
);
    import vcsc_pkg::*;

    result_t res;
    assign res = result_t'(m_tdata[RESULT_W-1:0]);

    // A stalled result beat must stay put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Back-pressure on the input only when a result is already waiting.
    a_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // Only a vend names a product.
    a_vend: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.status != ST_VENDED |-> res.vended_product == '0)
        else $error("vended product set on a non-vend result");

    // Return and restock both leave no credit behind.
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res.status == ST_RETURNED || res.status == ST_RESTOCKED)
            |-> res.credit_now == '0)
        else $error("credit left after return or restock");

    // Amount is only carried by return and report.
    a_amount: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.status != ST_RETURNED && res.status != ST_SALES
            |-> res.amount == '0 && m_tdata[M_TDATA_W-1:RESULT_W] == '0)
        else $error("amount or padding set where it should be zero");

endmodule

bind vending_credit_stock_controller_core vcsc_checker u_vcsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/tb_vending_credit_stock_controller_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vending controller core testbench
// Drives command beats into the core and predicts each result beat from a
// local model of credit, takings and shelf stock. Every result beat is
// checked field by field against the oldest prediction. A short directed
// part covers the codes and edge cases. Random customer sessions, coin
// bursts, reports, restocks and noise follow under several price and restock
// settings, with both sides paced in three ways.
// ----------------------------------------------------------------------------
module tb_vending_credit_stock_controller_core;
    import vcsc_pkg::*;

    localparam logic [KIND_W-1:0]    COIN_BOGUS      = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRICE_ITEM0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRICE_ITEM1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED    = 3'd7;
    localparam int                   QUIET_LIMIT     = 4000;
    localparam int                   CHUNK_ITEMS     = 215;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Local copy of the machine: settings and stored state.
    price_t      price_tab [NUM_PRICED];
    stock_t      refill_level;
    stock_t      shelf [NUM_ACTIVE];
    logic [15:0] till_credit;
    logic [31:0] takings;

    result_t     machine_replies [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int useful_sent   = 0;
    int ignored_sent  = 0;
    int beats_checked = 0;
    int mismatches    = 0;
    int credit_caps   = 0;
    int quiet_cycles  = 0;
    int seen_status [8];

    vending_credit_stock_controller_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5;
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
    end

    function automatic logic [16:0] coin_worth(input logic [KIND_W-1:0] kind);
        case (kind)
            COIN_100:  return 17'd100;
            COIN_500:  return 17'd500;
            COIN_1000: return 17'd1000;
            default:   return 17'd0;
        endcase
    endfunction

    function automatic logic [MASK_W-1:0] empty_shelves();
        logic [MASK_W-1:0] m;
        m = '0;
        for (int p = 0; p < NUM_ACTIVE; p++) begin
            if (shelf[p] == '0) m[p] = 1'b1;
        end
        return m;
    endfunction

    // Applies one accepted command to the local machine and queues the reply.
    task automatic run_command(input cmd_t c);
        result_t     r;
        logic [16:0] sum;
        logic [32:0] grown;
        price_t      cost;
        r = '0;
        case (c.func)
            FUNC_INSERT: begin
                sum = {1'b0, till_credit} + coin_worth(c.coin_kind);
                if (sum[16]) begin
                    till_credit = 16'hFFFF;
                    credit_caps++;
                end else begin
                    till_credit = sum[15:0];
                end
                r.status = ST_COIN_TAKEN;
            end
            FUNC_SELECT: begin
                if (c.product >= NUM_ACTIVE) begin
                    r.status = ST_SOLD_OUT;
                end else if (shelf[c.product] == '0) begin
                    r.status = ST_SOLD_OUT;
                end else if (till_credit < price_tab[c.product]) begin
                    r.status = ST_SHORT_FUNDS;
                end else begin
                    cost = price_tab[c.product];
                    till_credit = till_credit - cost;
                    grown = {1'b0, takings} + 33'(cost);
                    takings = grown[32] ? 32'hFFFF_FFFF : grown[31:0];
                    shelf[c.product] = shelf[c.product] - 1'b1;
                    r.status = ST_VENDED;
                    r.vended_product = c.product;
                end
            end
            FUNC_RETURN: begin
                r.amount = 32'(till_credit);
                till_credit = '0;
                r.status = ST_RETURNED;
            end
            FUNC_REPORT: begin
                r.amount = takings;
                r.status = ST_SALES;
            end
            FUNC_RESTOCK: begin
                for (int p = 0; p < NUM_ACTIVE; p++) shelf[p] = refill_level;
                takings = '0;
                till_credit = '0;
                r.status = ST_RESTOCKED;
            end
            default: return;
        endcase
        r.credit_now = till_credit;
        r.sold_out_mask = empty_shelves();
        machine_replies.push_back(r);
    endtask

    // Presents one command beat and returns just after the edge that takes it.
    task automatic send_command(input logic [FUNC_W-1:0] func, input logic [KIND_W-1:0] kind,
                                input logic [PROD_W-1:0] prod);
        cmd_t c;
        c.func = func;
        c.coin_kind = kind;
        c.product = prod;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        run_command(c);
        if (func <= FUNC_RESTOCK) useful_sent++;
        else ignored_sent++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx < NUM_PRICED) price_tab[idx] = val;
        else if (idx == CFG_RESTOCK_LEVEL) refill_level = val[7:0];
        @(posedge aclk);
    endtask

    // Stops sending, waits for every predicted reply, then allows for a
    // command still in flight that yields no reply.
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (machine_replies.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_setting(input int flavour);
        logic [15:0] v;
        logic [7:0]  lvl;
        for (int i = 0; i < NUM_PRICED; i++) begin
            case ($urandom_range(5))
                0:       v = 16'd0;
                1:       v = 16'hFFFF;
                2:       v = 16'($urandom_range(65535));
                default: v = 16'($urandom_range(1, 20) * 100);
            endcase
            if (i == flavour % NUM_PRICED) v = 16'hFFFF;
            if (i == (flavour + 1) % NUM_PRICED) v = 16'd0;
            write_register(CFG_IDX_W'(i), v);
        end
        case (flavour % 4)
            0:       lvl = 8'd255;
            1:       lvl = 8'd1;
            2:       lvl = 8'($urandom_range(2, 6));
            default: lvl = 8'($urandom_range(255));
        endcase
        // The upper byte is junk; only the low byte of the level is kept.
        write_register(CFG_RESTOCK_LEVEL, {8'($urandom), lvl});
    endtask

    task automatic test_coins_and_selection();
        send_command(FUNC_REPORT, COIN_100, 3'd0);
        send_command(FUNC_SELECT, COIN_100, 3'd0);
        send_command(FUNC_INSERT, COIN_100, 3'd0);
        send_command(FUNC_INSERT, COIN_500, 3'd7);
        send_command(FUNC_INSERT, COIN_1000, 3'd0);
        send_command(FUNC_INSERT, COIN_BOGUS, 3'd0);
        send_command(FUNC_SELECT, COIN_BOGUS, 3'd0);
        send_command(FUNC_SELECT, COIN_100, 3'd5);
        send_command(FUNC_SELECT, COIN_100, 3'd6);
        send_command(FUNC_SELECT, COIN_100, 3'd7);
        send_command(FUNC_REPORT, COIN_100, 3'd0);
        send_command(FUNC_RETURN, COIN_100, 3'd0);
        // Commands beyond restock are dropped without a reply.
        for (int k = 1; k <= 3; k++) begin
            send_command(FUNC_W'(FUNC_RESTOCK + k), COIN_BOGUS, 3'd7);
        end
        send_command(FUNC_RESTOCK, COIN_100, 3'd0);
    endtask

    task automatic test_price_and_restock_extremes();
        settle_idle();
        write_register(CFG_PRICE_ITEM0, 16'd0);
        write_register(CFG_PRICE_ITEM1, 16'hFFFF);
        write_register(CFG_RESTOCK_LEVEL, 16'hA501);
        write_register(CFG_UNMAPPED, 16'hFFFF);
        send_command(FUNC_RESTOCK, COIN_100, 3'd0);
        send_command(FUNC_SELECT, COIN_100, 3'd0);
        send_command(FUNC_SELECT, COIN_100, 3'd0);
        send_command(FUNC_SELECT, COIN_100, 3'd1);
        settle_idle();
        write_register(CFG_RESTOCK_LEVEL, 16'd0);
        send_command(FUNC_RESTOCK, COIN_100, 3'd0);
        send_command(FUNC_SELECT, COIN_100, 3'd2);
        settle_idle();
    endtask

    task automatic test_random_traffic(input int tx_idle, input int rx_idle, input int pass_no);
        int goal;
        int pick;
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        for (int k = 0; k < 2; k++) begin
            settle_idle();
            program_setting(2 * pass_no + k);
            goal = useful_sent + CHUNK_ITEMS;
            while (useful_sent < goal) begin
                pick = $urandom_range(99);
                if (pick < 2) begin
                    // A long run of large coins drives the credit to its ceiling.
                    repeat ($urandom_range(66, 72)) begin
                        send_command(FUNC_INSERT, COIN_1000, 3'($urandom));
                    end
                    send_command(FUNC_SELECT, 2'($urandom), 3'($urandom_range(NUM_ACTIVE - 1)));
                    send_command(FUNC_RETURN, 2'($urandom), 3'($urandom));
                end else if (pick < 70) begin
                    repeat ($urandom_range(1, 4)) begin
                        send_command(FUNC_INSERT,
                                     ($urandom_range(19) == 0) ? COIN_BOGUS
                                                               : 2'($urandom_range(2)),
                                     3'($urandom));
                    end
                    repeat ($urandom_range(1, 2)) begin
                        send_command(FUNC_SELECT, 2'($urandom),
                                     ($urandom_range(19) == 0) ? 3'($urandom_range(6, 7))
                                                               : 3'($urandom_range(5)));
                    end
                    if ($urandom_range(1) == 1) send_command(FUNC_RETURN, 2'($urandom), 3'($urandom));
                end else if (pick < 80) begin
                    send_command(FUNC_REPORT, 2'($urandom), 3'($urandom));
                end else if (pick < 85) begin
                    send_command(FUNC_RESTOCK, 2'($urandom), 3'($urandom));
                end else begin
                    send_command(3'($urandom), 2'($urandom), 3'($urandom));
                end
            end
        end
    endtask

    task automatic check_field(input string label, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
            mismatches++;
        end
    endtask

    // Receiver side: random back-pressure and checking of each result beat.
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[RESULT_W-1:0];
            beats_checked++;
            if (machine_replies.size() == 0) begin
                $display("%0t ns: result beat with none pending, got status %0d",
                         $time, got.status);
                mismatches++;
            end else begin
                want = machine_replies.pop_front();
                seen_status[want.status]++;
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("amount", want.amount, got.amount);
                check_field("credit_now", 32'(want.credit_now), 32'(got.credit_now));
                check_field("sold_out_mask", 32'(want.sold_out_mask),
                            32'(got.sold_out_mask));
                check_field("vended_product", 32'(want.vended_product),
                            32'(got.vended_product));
                check_field("padding", 32'd0, 32'(m_tdata[M_TDATA_W-1:RESULT_W]));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: no beat moved for %0d cycles", $time, QUIET_LIMIT);
            $display("vending_credit_stock_controller_core verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int p = 0; p < NUM_PRICED; p++) price_tab[p] = (p == 5) ? 16'd300 :
                                                 (p == 2 || p == 4) ? 16'd500 : 16'd700;
        for (int p = 0; p < NUM_ACTIVE; p++) shelf[p] = RESTOCK_RESET;
        for (int s = 0; s < 8; s++) seen_status[s] = 0;
        refill_level = RESTOCK_RESET;
        till_credit  = '0;
        takings      = '0;
        send_idle_pct = 19;
        recv_idle_pct = 56;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_coins_and_selection();
        test_price_and_restock_extremes();
        test_random_traffic(19, 56, 0);
        test_random_traffic(56, 19, 1);
        test_random_traffic(0, 0, 2);
        settle_idle();

        $display("Covered %0d command beats (%0d dropped codes) and %0d result beats.",
                 useful_sent + ignored_sent, ignored_sent, beats_checked);
        $display("Vends %0d, sold out %0d, short of funds %0d, restocks %0d, credit ceiling hit %0d.",
                 seen_status[ST_VENDED], seen_status[ST_SOLD_OUT],
                 seen_status[ST_SHORT_FUNDS], seen_status[ST_RESTOCKED], credit_caps);
        if (mismatches == 0) begin
            $display("vending_credit_stock_controller_core verification clean");
        end else begin
            $display("vending_credit_stock_controller_core verification failed");
        end
        $finish;
    end

endmodule
